// ===== rtl/mnsl_pkg.sv =====
// ----------------------------------------------------------------------------
// mnsl_pkg
// Shared types and constants of the nearest seed label block: payload
// structs of both channels, field widths, mode codes and register map.
// ----------------------------------------------------------------------------
package mnsl_pkg;

  // field widths
  localparam int COORD_W  = 10;
  localparam int SLOT_W   = 6;
  localparam int LABEL_W  = 7;
  localparam int DIST_W   = 11;
  localparam int SEED_W   = 2 * COORD_W;
  localparam int CNT_REG_W = 7;

  // mode codes of an input item
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // register map: word index taken from paddr[2]
  localparam logic REG_SEED_COUNT = 1'b0;
  localparam logic [CNT_REG_W-1:0] SEED_COUNT_RESET = 7'd50;

  typedef struct packed {
    logic               mode;
    logic [SLOT_W-1:0]  seed_index;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
  } in_item_t;

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic [DIST_W-1:0]  min_distance;
  } out_item_t;

endpackage

// ===== rtl/mnsl_seed_mem.sv =====
// ----------------------------------------------------------------------------
// mnsl_seed_mem
// Seed table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mnsl_seed_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 20
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/mnsl_dist_unit.sv =====
// ----------------------------------------------------------------------------
// mnsl_dist_unit
// Shared distance unit: Manhattan distance between the query point and
// the seed read from the table in this cycle.
// ----------------------------------------------------------------------------
module mnsl_dist_unit
  import mnsl_pkg::*;
(
  input  logic [COORD_W-1:0] qx,
  input  logic [COORD_W-1:0] qy,
  input  logic [COORD_W-1:0] sx,
  input  logic [COORD_W-1:0] sy,
  output logic [DIST_W-1:0]  seed_dist
);

  logic [COORD_W-1:0] dx;
  logic [COORD_W-1:0] dy;

  // absolute differences per axis
  assign dx = (qx > sx) ? (qx - sx) : (sx - qx);
  assign dy = (qy > sy) ? (qy - sy) : (sy - qy);

  // sum with one carry bit
  assign seed_dist = DIST_W'(dx) + DIST_W'(dy);

endmodule

// ===== rtl/mnsl_scan_ctrl.sv =====
// ----------------------------------------------------------------------------
// mnsl_scan_ctrl
// Sequencer of the block: writes seeds on load items and, on a query,
// walks the table one entry a cycle through the shared distance unit,
// keeping the running minimum, its label and a uniqueness flag.
// ----------------------------------------------------------------------------
module mnsl_scan_ctrl
  import mnsl_pkg::*;
#(
  parameter int MAX_SEEDS = 64,
  parameter int IDX_W     = 6,
  parameter int CNT_W     = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_data,
  input  logic [CNT_REG_W-1:0] seed_count,
  output logic                 wr_en,
  output logic [IDX_W-1:0]     wr_addr,
  output logic [SEED_W-1:0]    wr_data,
  output logic                 rd_en,
  output logic [IDX_W-1:0]     rd_addr,
  input  logic [SEED_W-1:0]    rd_data,
  output logic                 out_valid,
  output out_item_t            out_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   iss_r, iss_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               rvld_r, rvld_nxt;
  logic               rlast_r, rlast_nxt;
  logic [IDX_W-1:0]   ridx_r, ridx_nxt;
  logic [COORD_W-1:0] qx_r, qx_nxt;
  logic [COORD_W-1:0] qy_r, qy_nxt;
  logic [DIST_W-1:0]  best_r, best_nxt;
  logic [LABEL_W-1:0] label_r, label_nxt;
  logic               uniq_r, uniq_nxt;

  logic               accept;
  logic [CNT_W-1:0]   cnt_sat;
  logic [DIST_W-1:0]  seed_dist;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  // clamp the programmed count to the table depth
  assign cnt_sat = (32'(seed_count) > MAX_SEEDS) ? CNT_W'(MAX_SEEDS) : CNT_W'(seed_count);

  // load path: slots past the table are dropped
  assign wr_en   = accept && (in_data.mode == MODE_LOAD) &&
                   (32'(in_data.seed_index) < MAX_SEEDS);
  assign wr_addr = IDX_W'(in_data.seed_index);
  assign wr_data = {in_data.coord_y, in_data.coord_x};

  // read issue for the scan
  assign rd_en   = (state_r == ST_SCAN) && (iss_r < count_r);
  assign rd_addr = iss_r[IDX_W-1:0];

  mnsl_dist_unit u_dist (
    .qx        (qx_r),
    .qy        (qy_r),
    .sx        (rd_data[COORD_W-1:0]),
    .sy        (rd_data[SEED_W-1:COORD_W]),
    .seed_dist (seed_dist)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    iss_nxt   = iss_r;
    count_nxt = count_r;
    rvld_nxt  = 1'b0;
    rlast_nxt = rlast_r;
    ridx_nxt  = ridx_r;
    qx_nxt    = qx_r;
    qy_nxt    = qy_r;
    best_nxt  = best_r;
    label_nxt = label_r;
    uniq_nxt  = uniq_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_data.mode == MODE_QUERY)) begin
          qx_nxt    = in_data.coord_x;
          qy_nxt    = in_data.coord_y;
          count_nxt = cnt_sat;
          iss_nxt   = '0;
          if (cnt_sat == '0) begin
            // empty scan gives label 0 and distance 0
            best_nxt  = '0;
            label_nxt = '0;
            uniq_nxt  = 1'b0;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // issue side
        if (rd_en) begin
          rvld_nxt  = 1'b1;
          ridx_nxt  = iss_r[IDX_W-1:0];
          rlast_nxt = (iss_r == count_r - CNT_W'(1));
          iss_nxt   = iss_r + CNT_W'(1);
        end
        // compare side
        if (rvld_r) begin
          if ((ridx_r == '0) || (seed_dist < best_r)) begin
            best_nxt  = seed_dist;
            label_nxt = LABEL_W'(32'(ridx_r) + 1);
            uniq_nxt  = 1'b1;
          end else if (seed_dist == best_r) begin
            uniq_nxt  = 1'b0;
          end
          if (rlast_r) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rvld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rvld_r  <= rvld_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    iss_r   <= iss_nxt;
    count_r <= count_nxt;
    rlast_r <= rlast_nxt;
    ridx_r  <= ridx_nxt;
    qx_r    <= qx_nxt;
    qy_r    <= qy_nxt;
    best_r  <= best_nxt;
    label_r <= label_nxt;
    uniq_r  <= uniq_nxt;
  end

  // result strobe
  assign out_valid             = (state_r == ST_DONE);
  assign out_data.label        = uniq_r ? label_r : '0;
  assign out_data.min_distance = best_r;

endmodule

// ===== rtl/manhattan_nearest_seed_label.sv =====
// ----------------------------------------------------------------------------
// manhattan_nearest_seed_label
// Seed table with nearest seed search by Manhattan distance.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: an item transfers when start is high and busy is low.
//   A load item (mode 0) writes its point into slot seed_index in the
//   transfer cycle and gives no result; busy stays low, so another item
//   may follow in the next cycle.
//   A query item (mode 1) raises busy. The sequencer reads one table entry
//   a cycle from the seed memory and feeds it through the single distance
//   unit; seed_count is clamped to MAX_SEEDS, so entries above MAX_SEEDS
//   are not scanned. The memory read port sets the rate: one seed a cycle.
//   Result channel: out_valid is high for exactly one cycle with out_data;
//   the receiver must take it then. busy falls in the following cycle.
//   Config: APB register 0 (byte 0) holds seed_count, reset value 50.
//   Reset clears the sequencer and the register; the table is not
//   cleared, and a query must only scan slots that were loaded.
// ----------------------------------------------------------------------------
module manhattan_nearest_seed_label
  import mnsl_pkg::*;
#(
  parameter int MAX_SEEDS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_data,
  output logic        out_valid,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W = $clog2(MAX_SEEDS);
  localparam int CNT_W = $clog2(MAX_SEEDS + 1);

  logic [CNT_REG_W-1:0] seed_count_r;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [SEED_W-1:0]    wr_data;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic [SEED_W-1:0]    rd_data;

  // apb register file
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_count_r <= SEED_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_SEED_COUNT)) begin
      seed_count_r <= pwdata[CNT_REG_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_SEED_COUNT) ? 32'(seed_count_r) : 32'd0;

  mnsl_seed_mem #(
    .DEPTH (MAX_SEEDS),
    .AW    (IDX_W),
    .DW    (SEED_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mnsl_scan_ctrl #(
    .MAX_SEEDS (MAX_SEEDS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .seed_count (seed_count_r),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

endmodule

// ===== rtl/mnsl_checker.sv =====
// ----------------------------------------------------------------------------
// mnsl_checker
// Port-level checks of the nearest seed label block, bound to the top.
// ----------------------------------------------------------------------------
module mnsl_checker
  import mnsl_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_data,
  input logic      out_valid,
  input out_item_t out_data
);

  // a result only appears while a query is in progress
  a_result_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while not busy");

  // result strobe lasts one cycle and releases the block
  a_result_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("result strobe longer than one cycle");

  // a load transfer never occupies the block
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.mode == MODE_LOAD)) |=> !busy)
    else $error("load item made the block busy");

  // a query transfer always occupies the block
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.mode == MODE_QUERY)) |=> busy)
    else $error("query item did not start a scan");

  // distance stays within the grid span
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.min_distance <= 11'd2046))
    else $error("distance beyond grid span");

endmodule

bind manhattan_nearest_seed_label mnsl_checker u_mnsl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the nearest seed label block. Seeds are loaded
// into the table and grid points are queried under several seed_count
// settings written over the register port; a scoreboard predicts the label
// and distance of every query and checks each result strobe against it.
// ----------------------------------------------------------------------------
import mnsl_pkg::*;

localparam int TABLE_DEPTH = 64;

// tracks the seed table and seed_count, predicts and checks query answers
class seed_label_scoreboard;
  logic [SEED_W-1:0]    seed_points [TABLE_DEPTH];
  logic [CNT_REG_W-1:0] seed_count;
  out_item_t            pending_labels [$];
  int                   errors;
  int                   loads;
  int                   queries;
  int                   tied;

  function new();
    seed_count = SEED_COUNT_RESET;
    errors     = 0;
    loads      = 0;
    queries    = 0;
    tied       = 0;
    foreach (seed_points[i]) seed_points[i] = '0;
  endfunction

  function void write_register(logic [2:0] addr, logic [31:0] value);
    if (addr[2] == REG_SEED_COUNT) seed_count = value[CNT_REG_W-1:0];
  endfunction

  function int unsigned coord_gap(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
    return (a > b) ? int'(a - b) : int'(b - a);
  endfunction

  // update the table on a load, queue the expected answer on a query
  function void note_input(in_item_t item);
    int unsigned        scan_len;
    int unsigned        seed_dist;
    int unsigned        best;
    int unsigned        tie_count;
    int                 i;
    logic [LABEL_W-1:0] nearest;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    out_item_t          answer;
    if (item.mode == MODE_LOAD) begin
      seed_points[item.seed_index] = {item.coord_y, item.coord_x};
      loads++;
      return;
    end
    scan_len  = (seed_count > TABLE_DEPTH) ? TABLE_DEPTH : seed_count;
    best      = 0;
    tie_count = 0;
    nearest   = '0;
    for (i = 0; i < scan_len; i++) begin
      sx        = seed_points[i][COORD_W-1:0];
      sy        = seed_points[i][SEED_W-1:COORD_W];
      seed_dist = coord_gap(item.coord_x, sx) + coord_gap(item.coord_y, sy);
      if (i == 0 || seed_dist < best) begin
        best      = seed_dist;
        tie_count = 1;
        nearest   = LABEL_W'(i + 1);
      end else if (seed_dist == best) begin
        tie_count++;
      end
    end
    if (tie_count != 1) nearest = '0;
    if (tie_count > 1) tied++;
    answer.label        = nearest;
    answer.min_distance = DIST_W'(best);
    pending_labels.push_back(answer);
    queries++;
  endfunction

  // compare one result strobe with the oldest outstanding query
  function void check_result(out_item_t got);
    out_item_t want;
    if (pending_labels.size() == 0) begin
      $error("result with no query outstanding: label %0d min_distance %0d",
             got.label, got.min_distance);
      errors++;
      return;
    end
    want = pending_labels.pop_front();
    if (got.label !== want.label) begin
      $error("label mismatch: expected %0d, actual %0d", want.label, got.label);
      errors++;
    end
    if (got.min_distance !== want.min_distance) begin
      $error("min_distance mismatch: expected %0d, actual %0d",
             want.min_distance, got.min_distance);
      errors++;
    end
  endfunction
endclass

module testbench;

  localparam int         CYCLE_LIMIT     = 800000;
  localparam int         TAIL_CYCLES     = 80;
  localparam int         NUM_PHASES      = 10;
  localparam int         PHASE_ITEMS     = 154;
  localparam int         IN_W            = $bits(in_item_t);
  localparam logic [2:0] ADDR_SEED_COUNT = {REG_SEED_COUNT, 2'b00};
  localparam logic [2:0] ADDR_UNMAPPED   = {~REG_SEED_COUNT, 2'b00};

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        start     = 1'b0;
  logic        busy;
  in_item_t    in_data   = '0;
  logic        out_valid;
  out_item_t   out_data;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  seed_label_scoreboard board = new();

  int          cycle_count = 0;
  int          idle_pct    = 0;
  int          reg_writes  = 0;
  int unsigned span        = 1023;
  int unsigned base_x      = 0;
  int unsigned base_y      = 0;

  manhattan_nearest_seed_label u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  // result monitor: every strobe is a transfer
  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_result(out_data);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $error("no progress after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // hold the input channel off with noise on the data lines
  task automatic idle_input(int unsigned cycles);
    start   <= 1'b0;
    in_data <= IN_W'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  // one input transfer; start stays high for a following item
  task automatic send_item(logic mode, int unsigned slot, int unsigned x, int unsigned y);
    in_item_t item;
    item.mode       = mode;
    item.seed_index = SLOT_W'(slot);
    item.coord_x    = COORD_W'(x);
    item.coord_y    = COORD_W'(y);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) idle_input($urandom_range(1, 9));
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
    board.note_input(item);
  endtask

  // wait for all answers and for the block to go quiet
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (board.pending_labels.size() != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  // apb write: setup then access, then the bus returns to idle
  task automatic cfg_write(logic [2:0] addr, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.write_register(addr, value);
    reg_writes++;
    @(posedge clk);
  endtask

  function automatic int unsigned near_coord(int unsigned base);
    return base + $urandom_range(0, span);
  endfunction

  initial begin
    int unsigned new_count;
    int unsigned active;
    int unsigned pick;
    int          phase;
    int          n;
    int          s;

    // reset
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    idle_pct = 20;

    // directed: empty scan needs no seeds
    cfg_write(ADDR_SEED_COUNT, 32'd0);
    send_item(MODE_QUERY, 0, 1023, 1023);
    send_item(MODE_QUERY, 63, 0, 0);

    // directed: seeds in the four corners
    send_item(MODE_LOAD, 0, 0, 0);
    send_item(MODE_LOAD, 1, 1023, 1023);
    send_item(MODE_LOAD, 2, 1023, 0);
    send_item(MODE_LOAD, 3, 0, 1023);

    // directed: single seed, largest distance and zero distance
    drain_results();
    cfg_write(ADDR_SEED_COUNT, 32'd1);
    send_item(MODE_QUERY, 0, 1023, 1023);
    drain_results();
    // write to the unmapped word leaves the count alone
    cfg_write(ADDR_UNMAPPED, 32'hFFFF_FFFF);
    send_item(MODE_QUERY, 0, 0, 0);

    // directed: two seeds at equal distance give a tied minimum
    drain_results();
    cfg_write(ADDR_SEED_COUNT, 32'd2);
    send_item(MODE_QUERY, 0, 512, 511);
    send_item(MODE_QUERY, 0, 1023, 1023);

    // directed: four seeds, each query with a unique nearest seed
    drain_results();
    cfg_write(ADDR_SEED_COUNT, 32'd4);
    send_item(MODE_QUERY, 0, 1023, 0);
    send_item(MODE_QUERY, 0, 511, 511);
    send_item(MODE_QUERY, 0, 512, 512);

    // fill the whole table so any later count scans written slots only
    for (s = 0; s < TABLE_DEPTH; s++) begin
      send_item(MODE_LOAD, s, $urandom_range(0, 1023), $urandom_range(0, 1023));
    end

    // random phases, each with its own count, spread and idling
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      drain_results();
      case (phase)
        0: new_count = 127;
        1: new_count = 64;
        2: new_count = 65;
        3: new_count = 1;
        4: new_count = 0;
        5: new_count = 2;
        default: begin
          new_count = ($urandom_range(3) == 0) ? $urandom_range(0, 127)
                                                : $urandom_range(1, 16);
        end
      endcase
      cfg_write(ADDR_SEED_COUNT, ($urandom & ~32'h7F) | new_count);
      if ($urandom_range(1) == 0) cfg_write(ADDR_UNMAPPED, $urandom);
      active = (new_count > TABLE_DEPTH) ? TABLE_DEPTH : new_count;

      // narrow spreads make ties and short distances common
      pick = $urandom_range(4);
      case (pick)
        0: span = 1023;
        1: span = 255;
        2: span = 31;
        3: span = 7;
        default: span = 2;
      endcase
      base_x = $urandom_range(0, 1023 - span);
      base_y = $urandom_range(0, 1023 - span);

      if (phase == NUM_PHASES - 1) idle_pct = 0;
      else begin
        pick = $urandom_range(2);
        idle_pct = (pick == 0) ? 0 : ((pick == 1) ? 25 : 45);
      end

      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < 35) begin
          // loads mostly land inside the scanned range
          if (active > 0 && $urandom_range(3) != 0) s = $urandom_range(0, active - 1);
          else s = $urandom_range(0, TABLE_DEPTH - 1);
          send_item(MODE_LOAD, s, near_coord(base_x), near_coord(base_y));
        end else begin
          send_item(MODE_QUERY, $urandom_range(0, 63), near_coord(base_x),
                    near_coord(base_y));
        end
      end
    end

    // wrap up
    start <= 1'b0;
    do @(posedge clk); while (board.pending_labels.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d seed loads and %0d queries, %0d of them with a tied minimum,",
             board.loads, board.queries, board.tied);
    $display("over %0d register writes including empty and saturated counts", reg_writes);
    if (board.errors == 0 && board.pending_labels.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/mnsl_pkg.sv
rtl/mnsl_seed_mem.sv
rtl/mnsl_dist_unit.sv
rtl/mnsl_scan_ctrl.sv
rtl/manhattan_nearest_seed_label.sv
rtl/mnsl_checker.sv
test/testbench.sv
